[sv/grw_pkg.sv]
`timescale 1ns / 1ps

package grw_pkg;

  localparam int POSITION_WIDTH_DEF = 16;
  localparam int TOTAL_WIDTH_DEF    = 48;

  localparam int UPPER_W      = 15;
  localparam int LOWER_W      = 16;
  localparam int SEED_W       = 64;
  localparam int STEPS_W      = 32;
  localparam int TOTAL_OUT_W  = 48;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [UPPER_W-1:0]        UPPER_RESET  = 15'd10;
  localparam logic signed [LOWER_W-1:0] LOWER_RESET  = -16'sd5;
  localparam logic [SEED_W-1:0]         SEED_DEFAULT = 64'h4d59_5df4_d0f3_3173;

  localparam int XS_SHIFT_A = 13;
  localparam int XS_SHIFT_B = 7;
  localparam int XS_SHIFT_C = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UPPER = 2'd0,
    REG_LOWER = 2'd1,
    REG_SEED  = 2'd2
  } grw_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } grw_state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } grw_cmd_t;

  typedef struct packed {
    logic hit;
  } grw_sts_t;

endpackage

[sv/gamblers_ruin_walk_engine.sv]
`timescale 1ns / 1ps
// An item starts a walk; at a barrier, the result is registered once the output slot is free.
// The walk makes one xorshift64 flip per cycle, so the flip loop sets the rate.
// A new item is taken only in the idle state, once the last result is registered.
// Reset is synchronous and active low; barriers and seed return to their defaults.
// The seed reloads at reset and on a seed write outside a flip; totals clear at reset.

module gamblers_ruin_walk_engine import grw_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int TOTAL_WIDTH    = TOTAL_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_clear_totals,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_outcome,
  output logic [STEPS_W-1:0]     out_scenario_flips,
  output logic [TOTAL_OUT_W-1:0] out_total_wins,
  output logic [TOTAL_OUT_W-1:0] out_total_losses,
  output logic [TOTAL_OUT_W-1:0] out_total_flips,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]      cfg_data
);

  grw_cmd_t cmd;
  grw_sts_t sts;

  assign cfg_ready = 1'b1;

  grw_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  grw_datapath #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .TOTAL_WIDTH    (TOTAL_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .clear_totals   (in_clear_totals),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outcome        (out_outcome),
    .scenario_flips (out_scenario_flips),
    .total_wins     (out_total_wins),
    .total_losses   (out_total_losses),
    .total_flips    (out_total_flips)
  );

endmodule

[sv/grw_datapath.sv]
`timescale 1ns / 1ps

module grw_datapath import grw_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int TOTAL_WIDTH    = TOTAL_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  grw_cmd_t                  cmd,
  output grw_sts_t                  sts,
  input  logic                      clear_totals,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [SEED_W-1:0]         cfg_data,
  output logic                      outcome,
  output logic [STEPS_W-1:0]        scenario_flips,
  output logic [TOTAL_OUT_W-1:0]    total_wins,
  output logic [TOTAL_OUT_W-1:0]    total_losses,
  output logic [TOTAL_OUT_W-1:0]    total_flips
);

  localparam logic signed [33:0] POS_LIM = (34'sd1 <<< (POSITION_WIDTH - 1)) - 34'sd1;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;
  localparam logic [STEPS_W-1:0] STEPS_MAX = '1;

  function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] x;
    x = s;
    x = x ^ (x << XS_SHIFT_A);
    x = x ^ (x >> XS_SHIFT_B);
    x = x ^ (x << XS_SHIFT_C);
    return x;
  endfunction

  logic [UPPER_W-1:0]               upper_r;
  logic signed [LOWER_W-1:0]        lower_r;
  logic [SEED_W-1:0]                rng_r;
  logic signed [POSITION_WIDTH-1:0] pos_r;
  logic signed [POSITION_WIDTH-1:0] hi_r;
  logic signed [POSITION_WIDTH-1:0] lo_r;
  logic [STEPS_W-1:0]               steps_r;
  logic                             loss_r;
  logic [TOTAL_WIDTH-1:0]           wins_r;
  logic [TOTAL_WIDTH-1:0]           losses_r;
  logic [TOTAL_WIDTH-1:0]           flips_r;
  logic [TOTAL_WIDTH-1:0]           wins_nxt;
  logic [TOTAL_WIDTH-1:0]           losses_nxt;
  logic                             out_outcome_r;
  logic [STEPS_W-1:0]               out_steps_r;
  logic [TOTAL_OUT_W-1:0]           out_wins_r;
  logic [TOTAL_OUT_W-1:0]           out_losses_r;
  logic [TOTAL_OUT_W-1:0]           out_flips_r;

  logic [SEED_W-1:0]                rng_nxt;
  logic signed [POSITION_WIDTH-1:0] pos_nxt;
  logic signed [33:0]               upper_ext;
  logic signed [33:0]               lower_ext;
  logic signed [33:0]               hi_sel;
  logic signed [33:0]               lo_sel;

  always_comb begin
    upper_ext = signed'(34'(upper_r));
    lower_ext = 34'(lower_r);
    if (upper_ext < 34'sd1) begin
      hi_sel = 34'sd1;
    end else if (upper_ext > POS_LIM) begin
      hi_sel = POS_LIM;
    end else begin
      hi_sel = upper_ext;
    end
    if (lower_ext > -34'sd1) begin
      lo_sel = -34'sd1;
    end else if (lower_ext < -POS_LIM) begin
      lo_sel = -POS_LIM;
    end else begin
      lo_sel = lower_ext;
    end
  end

  always_comb begin
    rng_nxt = xorshift(rng_r);
    pos_nxt = rng_nxt[0] ? pos_r + POSITION_WIDTH'(1) : pos_r - POSITION_WIDTH'(1);
    sts.hit = (pos_nxt == hi_r) || (pos_nxt == lo_r);
    wins_nxt   = (!loss_r && wins_r != TOTAL_MAX) ? wins_r + TOTAL_WIDTH'(1) : wins_r;
    losses_nxt = (loss_r && losses_r != TOTAL_MAX) ? losses_r + TOTAL_WIDTH'(1) : losses_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= UPPER_RESET;
      lower_r  <= LOWER_RESET;
      rng_r    <= SEED_DEFAULT;
      pos_r    <= '0;
      wins_r   <= '0;
      losses_r <= '0;
      flips_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_UPPER: upper_r <= cfg_data[UPPER_W-1:0];
          REG_LOWER: lower_r <= signed'(cfg_data[LOWER_W-1:0]);
          REG_SEED:  rng_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start) begin
        pos_r <= '0;
        if (clear_totals) begin
          wins_r   <= '0;
          losses_r <= '0;
          flips_r  <= '0;
        end
      end
      if (cmd.step) begin
        rng_r   <= rng_nxt;
        pos_r   <= pos_nxt;
        flips_r <= (flips_r != TOTAL_MAX) ? flips_r + TOTAL_WIDTH'(1) : flips_r;
      end
      if (cmd.finish) begin
        wins_r   <= wins_nxt;
        losses_r <= losses_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hi_r    <= hi_sel[POSITION_WIDTH-1:0];
      lo_r    <= lo_sel[POSITION_WIDTH-1:0];
      steps_r <= '0;
    end
    if (cmd.step) begin
      steps_r <= (steps_r != STEPS_MAX) ? steps_r + STEPS_W'(1) : steps_r;
      loss_r  <= (pos_nxt == lo_r);
    end
    if (cmd.finish) begin
      out_outcome_r <= loss_r;
      out_steps_r   <= steps_r;
      out_wins_r    <= TOTAL_OUT_W'(wins_nxt);
      out_losses_r  <= TOTAL_OUT_W'(losses_nxt);
      out_flips_r   <= TOTAL_OUT_W'(flips_r);
    end
  end

  assign outcome        = out_outcome_r;
  assign scenario_flips = out_steps_r;
  assign total_wins     = out_wins_r;
  assign total_losses   = out_losses_r;
  assign total_flips    = out_flips_r;

  a_step_inside: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (pos_r != hi_r) && (pos_r != lo_r))
    else $error("Walk stepped from a barrier position.");

  a_step_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (steps_r != '0))
    else $error("Scenario flip count did not advance.");

  a_finish_at_barrier: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (pos_r == hi_r) || (pos_r == lo_r))
    else $error("Scenario finished away from a barrier.");

endmodule

[sv/grw_controller.sv]
`timescale 1ns / 1ps

module grw_controller import grw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output grw_cmd_t cmd,
  input  grw_sts_t sts
);

  grw_state_t state_r;
  grw_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.hit) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = slot_free;
      end
      default: ;
    endcase
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("Result appeared without a finished scenario.");

  a_finish_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> $past(state_r == ST_RUN) || $past(state_r == ST_FINISH))
    else $error("Finish entered without a walk.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r || out_ready)
    else $error("Pending result overwritten.");

endmodule
